// File: sv/bst_pkg.sv
package bst_pkg;

  localparam int NUM_BATTERIES_DEF = 2;

  localparam int VOLT_W = 14;
  localparam int CURR_W = 14;
  localparam int IMAX_W = 13;
  localparam int TEMP_W = 8;
  localparam int TYPE_W = 2;
  localparam int CAP_W  = 7;
  localparam int DUR_W  = 16;
  localparam int CYC_W  = 32;
  localparam int SEC_W  = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_START  = 2'd2,
    ACT_STOP   = 2'd3
  } bst_action_t;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_RUN  = 2'd1,
    PHASE_DONE = 2'd2
  } bst_phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_VOLTAGE  = 3'd0,
    REG_MAX_VOLTAGE  = 3'd1,
    REG_MAX_CURRENT  = 3'd2,
    REG_MAX_TEMP     = 3'd3,
    REG_BATTERY_TYPE = 3'd4,
    REG_CRIT_CAP     = 3'd5,
    REG_TEST_DUR     = 3'd6
  } bst_reg_t;

  localparam logic [VOLT_W-1:0] MIN_VOLTAGE_RST = 14'd10500;
  localparam logic [VOLT_W-1:0] MAX_VOLTAGE_RST = 14'd14400;
  localparam logic [IMAX_W-1:0] MAX_CURRENT_RST = 13'd5000;
  localparam logic [TEMP_W-1:0] MAX_TEMP_RST    = 8'd50;
  localparam logic [TYPE_W-1:0] BATT_TYPE_RST   = 2'd0;
  localparam logic [CAP_W-1:0]  CRIT_CAP_RST    = 7'd10;
  localparam logic [DUR_W-1:0]  TEST_DUR_RST    = 16'd60;

  localparam logic signed [CURR_W-1:0] CHARGE_ON_MA    = 14'sd100;
  localparam logic signed [CURR_W-1:0] DISCHARGE_ON_MA = -14'sd100;

  typedef logic [VOLT_W-1:0] soc_row_t [6];
  localparam soc_row_t SOC_THRESH [3] = '{
    '{14'd13000, 14'd12500, 14'd12000, 14'd11500, 14'd11000, 14'd10500},
    '{14'd14000, 14'd13500, 14'd13000, 14'd12500, 14'd12000, 14'd11500},
    '{14'd12000, 14'd11500, 14'd11000, 14'd10500, 14'd10000, 14'd9500}
  };
  typedef logic [CAP_W-1:0] soc_val_t [6];
  localparam soc_val_t SOC_VALUE = '{7'd100, 7'd90, 7'd75, 7'd50, 7'd25, 7'd10};

  typedef struct packed {
    logic [VOLT_W-1:0] min_voltage;
    logic [VOLT_W-1:0] max_voltage;
    logic [IMAX_W-1:0] max_current;
    logic [TEMP_W-1:0] max_temp;
    logic [TYPE_W-1:0] batt_kind;
    logic [CAP_W-1:0]  crit_cap;
    logic [DUR_W-1:0]  test_dur;
  } bst_cfg_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             healthy;
    logic             charge;
    logic             discharge;
  } bst_eval_t;

  typedef struct packed {
    logic        tick;
    logic        sel;
    bst_action_t act;
    bst_eval_t   eval;
  } bst_cmd_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             charging;
    logic             healthy;
    logic             running;
    bst_phase_t       phase;
    logic [CYC_W-1:0] cycles;
    logic [DUR_W-1:0] elapsed;
  } bst_stat_t;

  // Walks the six thresholds from the lowest upward; the unknown type reads as empty.
  function automatic logic [CAP_W-1:0] soc_lookup(input logic [VOLT_W-1:0] mv,
                                                  input logic [TYPE_W-1:0] btype);
    logic [CAP_W-1:0] cap;
    cap = '0;
    if (btype != 2'd3) begin
      for (int i = 5; i >= 0; i--) begin
        if (mv >= SOC_THRESH[btype][i]) cap = SOC_VALUE[i];
      end
    end
    return cap;
  endfunction

endpackage

// File: sv/bst_eval.sv
module bst_eval import bst_pkg::*; (
  input  logic [VOLT_W-1:0]        batt_mv,
  input  logic signed [CURR_W-1:0] current_ma,
  input  logic [TEMP_W-1:0]        temperature_c,
  input  bst_cfg_t                 cfg,
  output bst_eval_t                eval
);

  logic [CAP_W-1:0]  cap;
  logic [CURR_W-1:0] mag;

  assign cap = soc_lookup(batt_mv, cfg.batt_kind);
  // The most negative code has no positive twin but still fits unsigned.
  assign mag = current_ma[CURR_W-1] ? CURR_W'(-current_ma) : CURR_W'(current_ma);

  always_comb begin
    eval.capacity  = cap;
    eval.healthy   = (batt_mv >= cfg.min_voltage) && (batt_mv <= cfg.max_voltage) &&
                     (mag <= CURR_W'(cfg.max_current)) &&
                     (temperature_c <= cfg.max_temp) && (cap >= cfg.crit_cap);
    eval.charge    = current_ma > CHARGE_ON_MA;
    eval.discharge = current_ma < DISCHARGE_ON_MA;
  end

endmodule

// File: sv/bst_lane.sv
module bst_lane import bst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  bst_cmd_t         cmd,
  input  logic [DUR_W-1:0] test_dur,
  output bst_stat_t        stat
);

  // Elapsed time is kept per battery instead of a start timestamp; both
  // wrap modulo 2^32 in the same way.
  logic [SEC_W-1:0] elapsed_r, elapsed_nxt;
  logic             running_r, running_nxt;
  bst_phase_t       phase_r, phase_nxt;
  logic [CYC_W-1:0] cycles_r, cycles_nxt;
  logic             armed_r, armed_nxt;
  logic             charging_r, charging_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             healthy_r, healthy_nxt;

  always_comb begin
    elapsed_nxt  = elapsed_r;
    running_nxt  = running_r;
    phase_nxt    = phase_r;
    cycles_nxt   = cycles_r;
    armed_nxt    = armed_r;
    charging_nxt = charging_r;
    cap_nxt      = cap_r;
    healthy_nxt  = healthy_r;
    if (cmd.tick) begin
      elapsed_nxt = elapsed_r + SEC_W'(1);
      if (running_r && (elapsed_nxt >= SEC_W'(test_dur))) begin
        running_nxt = 1'b0;
        phase_nxt   = PHASE_DONE;
      end
    end
    if (cmd.sel) begin
      case (cmd.act)
        ACT_SAMPLE: begin
          cap_nxt     = cmd.eval.capacity;
          healthy_nxt = cmd.eval.healthy;
          if (cmd.eval.charge) begin
            charging_nxt = 1'b1;
            armed_nxt    = 1'b1;
          end else if (cmd.eval.discharge) begin
            charging_nxt = 1'b0;
            if (armed_r) begin
              if (cycles_r != '1) cycles_nxt = cycles_r + CYC_W'(1);
              armed_nxt = 1'b0;
            end
          end
          if (running_r && (elapsed_r >= SEC_W'(test_dur))) begin
            running_nxt = 1'b0;
            phase_nxt   = PHASE_DONE;
          end
        end
        ACT_START: begin
          running_nxt = 1'b1;
          phase_nxt   = PHASE_RUN;
          elapsed_nxt = '0;
        end
        ACT_STOP: begin
          running_nxt = 1'b0;
          phase_nxt   = PHASE_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      running_r  <= 1'b0;
      phase_r    <= PHASE_IDLE;
      cycles_r   <= '0;
      armed_r    <= 1'b0;
      charging_r <= 1'b0;
      cap_r      <= '0;
      healthy_r  <= 1'b0;
    end else begin
      elapsed_r  <= elapsed_nxt;
      running_r  <= running_nxt;
      phase_r    <= phase_nxt;
      cycles_r   <= cycles_nxt;
      armed_r    <= armed_nxt;
      charging_r <= charging_nxt;
      cap_r      <= cap_nxt;
      healthy_r  <= healthy_nxt;
    end
  end

  // Status after this beat's update, for the result register.
  always_comb begin
    stat.capacity = cap_nxt;
    stat.charging = charging_nxt;
    stat.healthy  = healthy_nxt;
    stat.running  = running_nxt;
    stat.phase    = phase_nxt;
    stat.cycles   = cycles_nxt;
    if (phase_nxt == PHASE_IDLE) begin
      stat.elapsed = '0;
    end else if (|elapsed_nxt[SEC_W-1:DUR_W]) begin
      stat.elapsed = '1;
    end else begin
      stat.elapsed = elapsed_nxt[DUR_W-1:0];
    end
  end

endmodule

// File: sv/battery_status_tracker.sv
// Channel   Direction  Handshake                Payload
// in_       input      in_valid / in_ready      action, battery_index, voltage, current, temp
// out_      output     out_valid / out_ready    one status beat per input beat
// cfg_      input      cfg_we                   cfg_addr selects register, cfg_wdata
//
// Every input beat yields one result beat, loaded into the result register when it leaves the input register.
// One beat is accepted per cycle while no stalled result holds the input register; the
// battery state updates together with the result register, from the input register.
// Synchronous active-low reset clears all battery state and loads the
// register defaults.
// A stalled result holds the result register; the input register still
// takes one more beat before in_ready drops.
module battery_status_tracker import bst_pkg::*; #(
  parameter int NUM_BATTERIES = NUM_BATTERIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic                    in_battery_index,
  input  logic [VOLT_W-1:0]       in_batt_mv,
  input  logic signed [CURR_W-1:0] in_current_ma,
  input  logic [TEMP_W-1:0]       in_temperature_c,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_battery_number,
  output logic [CAP_W-1:0]        out_capacity_percent,
  output logic                    out_charging,
  output logic                    out_healthy,
  output logic                    out_test_in_progress,
  output logic [1:0]              out_test_phase,
  output logic [CYC_W-1:0]        out_cycles,
  output logic [DUR_W-1:0]        out_test_elapsed_s,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int BW = (NUM_BATTERIES > 1) ? $clog2(NUM_BATTERIES) : 1;

  bst_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_voltage  <= MIN_VOLTAGE_RST;
      cfg_r.max_voltage  <= MAX_VOLTAGE_RST;
      cfg_r.max_current  <= MAX_CURRENT_RST;
      cfg_r.max_temp     <= MAX_TEMP_RST;
      cfg_r.batt_kind    <= BATT_TYPE_RST;
      cfg_r.crit_cap     <= CRIT_CAP_RST;
      cfg_r.test_dur     <= TEST_DUR_RST;
    end else if (cfg_we) begin
      case (bst_reg_t'(cfg_addr))
        REG_MIN_VOLTAGE:  cfg_r.min_voltage  <= cfg_wdata[VOLT_W-1:0];
        REG_MAX_VOLTAGE:  cfg_r.max_voltage  <= cfg_wdata[VOLT_W-1:0];
        REG_MAX_CURRENT:  cfg_r.max_current  <= cfg_wdata[IMAX_W-1:0];
        REG_MAX_TEMP:     cfg_r.max_temp     <= cfg_wdata[TEMP_W-1:0];
        REG_BATTERY_TYPE: cfg_r.batt_kind    <= cfg_wdata[TYPE_W-1:0];
        REG_CRIT_CAP:     cfg_r.crit_cap     <= cfg_wdata[CAP_W-1:0];
        REG_TEST_DUR:     cfg_r.test_dur     <= cfg_wdata[DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  logic                     s1_valid_r;
  bst_action_t              s1_action_r;
  logic                     s1_index_r;
  logic [VOLT_W-1:0]        s1_voltage_r;
  logic signed [CURR_W-1:0] s1_current_r;
  logic [TEMP_W-1:0]        s1_temp_r;
  logic                     advance;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r  <= bst_action_t'(in_action);
      s1_index_r   <= in_battery_index;
      s1_voltage_r <= in_batt_mv;
      s1_current_r <= in_current_ma;
      s1_temp_r    <= in_temperature_c;
    end
  end

  bst_eval_t eval;

  bst_eval u_eval (
    .batt_mv       (s1_voltage_r),
    .current_ma    (s1_current_r),
    .temperature_c (s1_temp_r),
    .cfg           (cfg_r),
    .eval          (eval)
  );

  // A tick always reports battery 0.
  logic          is_tick;
  logic          rep_index;
  logic          in_range;
  logic [BW-1:0] rep_sel;

  assign is_tick   = (s1_action_r == ACT_TICK);
  assign rep_index = is_tick ? 1'b0 : s1_index_r;
  assign in_range  = (32'(rep_index) < NUM_BATTERIES);
  assign rep_sel   = BW'(rep_index);

  bst_stat_t stat [NUM_BATTERIES];

  for (genvar g = 0; g < NUM_BATTERIES; g++) begin : g_lane
    bst_cmd_t cmd;
    always_comb begin
      cmd.tick = advance && is_tick;
      cmd.sel  = advance && !is_tick && in_range && (32'(s1_index_r) == g);
      cmd.act  = s1_action_r;
      cmd.eval = eval;
    end
    bst_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .test_dur (cfg_r.test_dur),
      .stat     (stat[g])
    );
  end

  bst_stat_t sel_stat;

  always_comb begin
    if (in_range) begin
      sel_stat = stat[rep_sel];
    end else begin
      sel_stat = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_battery_number   <= rep_index;
      out_capacity_percent <= sel_stat.capacity;
      out_charging         <= sel_stat.charging;
      out_healthy          <= sel_stat.healthy;
      out_test_in_progress <= sel_stat.running;
      out_test_phase       <= sel_stat.phase;
      out_cycles           <= sel_stat.cycles;
      out_test_elapsed_s   <= sel_stat.elapsed;
    end
  end

  a_idle_no_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_test_phase == PHASE_IDLE) |-> (out_test_elapsed_s == '0))
    else $error("idle test reports elapsed time");

  a_running_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_test_in_progress |-> (out_test_phase == PHASE_RUN))
    else $error("running flag without running phase");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed beat produced no result");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_action_r) && $stable(s1_index_r))
    else $error("input register lost a pending beat");

  a_tick_battery0: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick |=> !out_battery_number)
    else $error("tick result not on battery 0");

endmodule
